// ----- src/spoq_pkg.sv -----
// Package: constants, record types and helpers for the sorted priority order queue.
`default_nettype none

package spoq_pkg;

  localparam int unsigned DEPTH     = 64;
  localparam int unsigned KEY_WIDTH = 16;
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_e;

  typedef struct packed {
    logic [KEY_WIDTH-1:0] key;
    logic [7:0]           pickup;
    logic [7:0]           dropoff;
    logic [1:0]           kind;
    logic [7:0]           tleft;
  } rec_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic                 ins;
    logic                 deq;
    logic [KEY_WIDTH-1:0] key;
  } cell_ctl_t;

  function automatic logic [KEY_WIDTH-1:0] to_key(input logic [15:0] st);
    logic [KEY_WIDTH+15:0] ext;
    ext = {{KEY_WIDTH{1'b0}}, st};
    return ext[KEY_WIDTH-1:0];
  endfunction

  function automatic logic [15:0] from_key(input logic [KEY_WIDTH-1:0] k);
    logic [KEY_WIDTH+15:0] ext;
    ext = {16'd0, k};
    return ext[15:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/spoq_if.sv -----
// Interfaces: request and response channels of the sorted priority order queue.
`default_nettype none

interface spoq_req_if;
  logic                valid;
  logic                ready;
  spoq_pkg::cmd_e      command;
  logic [15:0]         serve_time;
  logic [7:0]          pickup;
  logic [7:0]          dropoff;
  logic [1:0]          item_kind;
  logic [7:0]          time_left;

  modport source (output valid, command, serve_time, pickup, dropoff, item_kind, time_left,
                  input ready);
  modport sink   (input valid, command, serve_time, pickup, dropoff, item_kind, time_left,
                  output ready);
endinterface

interface spoq_rsp_if;
  logic                valid;
  logic                ready;
  logic                out_valid;
  logic [15:0]         out_serve_time;
  logic [7:0]          out_pickup;
  logic [7:0]          out_dropoff;
  logic [1:0]          out_kind;
  logic [7:0]          out_time_left;
  logic [6:0]          occupancy;
  logic                is_empty;
  logic                is_full;
  spoq_pkg::err_e      error;

  modport source (output valid, out_valid, out_serve_time, out_pickup, out_dropoff, out_kind,
                  out_time_left, occupancy, is_empty, is_full, error,
                  input ready);
  modport sink   (input valid, out_valid, out_serve_time, out_pickup, out_dropoff, out_kind,
                  out_time_left, occupancy, is_empty, is_full, error,
                  output ready);
endinterface

`default_nettype wire

// ----- src/spoq_cell.sv -----
// One slot of the sorted shift row: holds a record, shifts right on insert, left on pop.
`default_nettype none

module spoq_cell (
  input  wire                 clk_i,
  input  spoq_pkg::cell_ctl_t ctl_i,
  input  spoq_pkg::rec_t      new_rec_i,
  input  wire                 occ_i,
  input  spoq_pkg::rec_t      prev_rec_i,
  input  wire                 prev_gt_i,
  input  spoq_pkg::rec_t      next_rec_i,
  output spoq_pkg::rec_t      rec_o,
  output logic                gt_o
);

  spoq_pkg::rec_t rec_q, rec_d;
  logic           key_gt;

  // strict compare keeps equal keys in arrival order
  assign key_gt = rec_q.key > ctl_i.key;
  assign gt_o   = occ_i && key_gt;
  assign rec_o  = rec_q;

  always_comb begin
    rec_d = rec_q;
    if (ctl_i.ins) begin
      if (prev_gt_i) begin
        rec_d = prev_rec_i;
      end else if (!occ_i || key_gt) begin
        rec_d = new_rec_i;
      end
    end else if (ctl_i.deq) begin
      rec_d = next_rec_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

endmodule

`default_nettype wire

// ----- src/sorted_priority_order_queue_unit.sv -----
// Top level: sorted priority order queue built as a row of shifting record cells.
//
//  channel  dir  payload                                       transfer when
//  req_i    in   command, serve_time, pickup, dropoff, kind..   valid && ready
//  rsp_o    out  out_valid, record, occupancy, flags, error      valid && ready
//
// One request per cycle unless rsp_o stalls; the response appears in the cycle after it.
// Every cell compares its key with the new key at once, so an insert or a pop
// updates every cell at the same clock edge whatever the fill level.
// Reset clears the count and the response valid flag; cell contents stay unknown
// and are never read beyond the count.
// A stalled response holds the request side only when the response register is full.
`default_nettype none

module sorted_priority_order_queue_unit (
  input  wire              clk_i,
  input  wire              rst_ni,
  spoq_req_if.sink         req_i,
  spoq_rsp_if.source       rsp_o
);

  localparam int unsigned Depth = spoq_pkg::DEPTH;
  localparam int unsigned CntW  = spoq_pkg::CNT_W;

  logic [CntW-1:0]     count_q, count_d;
  logic                req_fire;
  logic                is_deq;
  logic                empty, full;
  spoq_pkg::cell_ctl_t ctl;
  spoq_pkg::rec_t      new_rec;
  spoq_pkg::rec_t      cell_rec [Depth];
  logic                cell_gt  [Depth];
  logic                cell_occ [Depth];

  logic                res_valid_q;
  logic                out_valid_q, out_valid_d;
  spoq_pkg::rec_t      out_rec_q, out_rec_d;
  spoq_pkg::err_e      err_q, err_d;
  logic [CntW-1:0]     occ_q;

  assign req_i.ready = !res_valid_q || rsp_o.ready;
  assign req_fire    = req_i.valid && req_i.ready;
  assign is_deq      = req_i.command == spoq_pkg::CMD_DEQ;
  assign empty       = count_q == '0;
  assign full        = count_q == CntW'(Depth);

  assign new_rec.key     = spoq_pkg::to_key(req_i.serve_time);
  assign new_rec.pickup  = req_i.pickup;
  assign new_rec.dropoff = req_i.dropoff;
  assign new_rec.kind    = req_i.item_kind;
  assign new_rec.tleft   = req_i.time_left;

  assign ctl.ins = req_fire && !is_deq && !full;
  assign ctl.deq = req_fire && is_deq && !empty;
  assign ctl.key = new_rec.key;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    assign cell_occ[i] = CntW'(i) < count_q;
    if (i == 0) begin : g_head
      spoq_cell u_cell (
        .clk_i     (clk_i),
        .ctl_i     (ctl),
        .new_rec_i (new_rec),
        .occ_i     (cell_occ[i]),
        .prev_rec_i(new_rec),
        .prev_gt_i (1'b0),
        .next_rec_i(cell_rec[i+1]),
        .rec_o     (cell_rec[i]),
        .gt_o      (cell_gt[i])
      );
    end else if (i == Depth - 1) begin : g_tail
      // tail is vacated by a pop, so its new contents do not matter
      spoq_cell u_cell (
        .clk_i     (clk_i),
        .ctl_i     (ctl),
        .new_rec_i (new_rec),
        .occ_i     (cell_occ[i]),
        .prev_rec_i(cell_rec[i-1]),
        .prev_gt_i (cell_gt[i-1]),
        .next_rec_i(new_rec),
        .rec_o     (cell_rec[i]),
        .gt_o      (cell_gt[i])
      );
    end else begin : g_mid
      spoq_cell u_cell (
        .clk_i     (clk_i),
        .ctl_i     (ctl),
        .new_rec_i (new_rec),
        .occ_i     (cell_occ[i]),
        .prev_rec_i(cell_rec[i-1]),
        .prev_gt_i (cell_gt[i-1]),
        .next_rec_i(cell_rec[i+1]),
        .rec_o     (cell_rec[i]),
        .gt_o      (cell_gt[i])
      );
    end
  end

  always_comb begin
    count_d     = count_q;
    out_valid_d = 1'b0;
    out_rec_d   = '0;
    err_d       = spoq_pkg::ERR_OK;
    if (is_deq) begin
      if (empty) begin
        err_d = spoq_pkg::ERR_EMPTY;
      end else begin
        out_valid_d = 1'b1;
        out_rec_d   = cell_rec[0];
        count_d     = count_q - CntW'(1);
      end
    end else begin
      if (full) begin
        err_d = spoq_pkg::ERR_FULL;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (req_fire) begin
        count_q     <= count_d;
        res_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      out_valid_q <= out_valid_d;
      out_rec_q   <= out_rec_d;
      err_q       <= err_d;
      occ_q       <= count_d;
    end
  end

  assign rsp_o.valid          = res_valid_q;
  assign rsp_o.out_valid      = out_valid_q;
  assign rsp_o.out_serve_time = spoq_pkg::from_key(out_rec_q.key);
  assign rsp_o.out_pickup     = out_rec_q.pickup;
  assign rsp_o.out_dropoff    = out_rec_q.dropoff;
  assign rsp_o.out_kind       = out_rec_q.kind;
  assign rsp_o.out_time_left  = out_rec_q.tleft;
  assign rsp_o.occupancy      = 7'(occ_q);
  assign rsp_o.is_empty       = occ_q == '0;
  assign rsp_o.is_full        = occ_q == CntW'(Depth);
  assign rsp_o.error          = err_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count above depth");

  a_count_enq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.ins |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not grow the count");

  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl.ins && !ctl.deq |=> $stable(count_q))
    else $error("count moved without an insert or pop");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && err_q == spoq_pkg::ERR_FULL |-> rsp_o.is_full)
    else $error("full error reported while not full");

  a_pop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && out_valid_q |-> err_q == spoq_pkg::ERR_OK && !rsp_o.is_full)
    else $error("popped record with an error or full flag");
`endif

endmodule

`default_nettype wire
